@@ design/kgbp_pkg.sv @@
// ----------------------------------------------------------------------------
// kgbp_pkg
// Shared types, constants and helpers for the kanji glyph blit planner.
// ----------------------------------------------------------------------------
package kgbp_pkg;

    // Font sheet geometry.
    localparam int CELL_SIZE     = 16;
    localparam int SHEET_COLUMNS = 32;

    // Pen position is 18-bit signed and saturates at its maximum.
    localparam int PEN_W = 18;
    localparam logic signed [PEN_W-1:0] PEN_MAX = 18'sd131071;

    // Working width for clip arithmetic.
    localparam int CALC_W = 19;

    // Character classification and Shift-JIS decode constants.
    localparam logic [15:0] ASCII_FIRST   = 16'h0020;
    localparam logic [15:0] ASCII_LAST    = 16'h007F;
    localparam logic [7:0]  LEAD_A_LO     = 8'h81;
    localparam logic [7:0]  LEAD_A_GAP_LO = 8'h85;
    localparam logic [7:0]  LEAD_A_GAP_HI = 8'h86;
    localparam logic [7:0]  LEAD_A_HI     = 8'h9F;
    localparam logic [7:0]  LEAD_B_LO     = 8'hE0;
    localparam logic [7:0]  LEAD_B_HI     = 8'hEF;
    localparam logic [7:0]  LEAD_A_BIAS   = 8'h70;
    localparam logic [7:0]  LEAD_B_BIAS   = 8'hB0;
    localparam logic [7:0]  TRAIL_LO      = 8'h40;
    localparam logic [7:0]  TRAIL_DEL     = 8'h7F;
    localparam logic [7:0]  TRAIL_MID     = 8'h9E;
    localparam logic [7:0]  TRAIL_HI_LO   = 8'h9F;
    localparam logic [7:0]  TRAIL_HI      = 8'hFC;
    localparam logic [7:0]  TRAIL_LO_BIAS = 8'd31;
    localparam logic [7:0]  TRAIL_HI_BIAS = 8'd126;
    localparam logic [7:0]  COL_SKIP      = 8'd95;
    localparam logic [7:0]  ROW_BASE      = 8'h20;
    localparam logic [7:0]  COL_BASE      = 8'h20;
    localparam logic [7:0]  ROW_SET1_LO   = 8'h21;
    localparam logic [7:0]  ROW_SET1_HI   = 8'h27;
    localparam logic [7:0]  ROW_SET2_LO   = 8'h30;
    localparam logic [7:0]  ROW_SET2_HI   = 8'h4F;
    localparam logic [11:0] SET2_GLYPH_BASE = 12'd1024;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CLIP_LEFT        = 3'd0,
        REG_CLIP_TOP         = 3'd1,
        REG_CLIP_WIDTH       = 3'd2,
        REG_CLIP_HEIGHT      = 3'd3,
        REG_LINE_START_X     = 3'd4,
        REG_LINE_START_Y     = 3'd5,
        REG_TRANSPARENT_MODE = 3'd6
    } cfg_reg_t;

    // Configuration register contents.
    typedef struct packed {
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic [14:0]        clip_width;
        logic [14:0]        clip_height;
        logic signed [15:0] line_start_x;
        logic signed [15:0] line_start_y;
        logic               transparent_mode;
    } cfg_t;

    // Input beat.
    typedef struct packed {
        logic [15:0] char_code;
        logic        last_of_line;
    } char_item_t;

    // Output beat.
    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [4:0]         blit_width;
        logic [4:0]         blit_height;
        logic [8:0]         source_x;
        logic [11:0]        source_y;
        logic               raster_op;
        logic               is_last;
    } blit_item_t;

    // Advance width of a character: half width for ASCII range, full cell otherwise.
    function automatic logic [4:0] char_width(input logic [15:0] code);
        logic [4:0] w;
        begin
            w = (code <= ASCII_LAST) ? 5'(CELL_SIZE / 2) : 5'(CELL_SIZE);
            return w;
        end
    endfunction

endpackage

@@ design/kgbp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// kgbp_cfg_regs
// Configuration register file; flags writes of the line start x register.
// ----------------------------------------------------------------------------
module kgbp_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [15:0]      wr_data,
    output kgbp_pkg::cfg_t   cfg,
    output logic             line_start_wr
);

    kgbp_pkg::cfg_t cfg_reg;
    kgbp_pkg::cfg_t cfg_next;
    logic           ls_wr;

    // Decode the register index and merge the write data.
    always_comb
    begin
        cfg_next = cfg_reg;
        ls_wr    = 1'b0;
        if (wr_en)
        begin
            unique case (kgbp_pkg::cfg_reg_t'(wr_index))
                kgbp_pkg::REG_CLIP_LEFT:        cfg_next.clip_left    = wr_data;
                kgbp_pkg::REG_CLIP_TOP:         cfg_next.clip_top     = wr_data;
                kgbp_pkg::REG_CLIP_WIDTH:       cfg_next.clip_width   = wr_data[14:0];
                kgbp_pkg::REG_CLIP_HEIGHT:      cfg_next.clip_height  = wr_data[14:0];
                kgbp_pkg::REG_LINE_START_X:
                begin
                    cfg_next.line_start_x = wr_data;
                    ls_wr                 = 1'b1;
                end
                kgbp_pkg::REG_LINE_START_Y:     cfg_next.line_start_y = wr_data;
                kgbp_pkg::REG_TRANSPARENT_MODE: cfg_next.transparent_mode = wr_data[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg           = cfg_reg;
    assign line_start_wr = ls_wr;

endmodule

@@ design/kgbp_glyph_index.sv @@
// ----------------------------------------------------------------------------
// kgbp_glyph_index
// Maps a character code to its cell index in the font sheet, converting
// Shift-JIS to JIS X 0208 rows on the way.
// ----------------------------------------------------------------------------
module kgbp_glyph_index (
    input  logic [15:0] char_code,
    output logic [11:0] glyph
);

    logic [7:0]  lead;
    logic [7:0]  trail;
    logic        lead_a;
    logic        lead_b;
    logic        trail_lo;
    logic        trail_hi;
    logic [7:0]  lead_rel;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        pair_ok;
    logic        set1;
    logic        set2;
    logic [7:0]  row_rel;
    logic [11:0] row_off;
    logic [11:0] col_off;

    assign lead  = char_code[7:0];
    assign trail = char_code[15:8];

    // Lead byte classes; the gap at 0x85..0x86 is not assigned.
    assign lead_a = (lead >= kgbp_pkg::LEAD_A_LO) && (lead <= kgbp_pkg::LEAD_A_HI) &&
                    !((lead >= kgbp_pkg::LEAD_A_GAP_LO) && (lead <= kgbp_pkg::LEAD_A_GAP_HI));
    assign lead_b = (lead >= kgbp_pkg::LEAD_B_LO) && (lead <= kgbp_pkg::LEAD_B_HI);

    // Trail byte classes select odd or even JIS row.
    assign trail_lo = (trail >= kgbp_pkg::TRAIL_LO) && (trail <= kgbp_pkg::TRAIL_MID) &&
                      (trail != kgbp_pkg::TRAIL_DEL);
    assign trail_hi = (trail >= kgbp_pkg::TRAIL_HI_LO) && (trail <= kgbp_pkg::TRAIL_HI);

    // JIS row and column from the byte pair.
    always_comb
    begin
        lead_rel = lead_b ? (lead - kgbp_pkg::LEAD_B_BIAS) : (lead - kgbp_pkg::LEAD_A_BIAS);
        row      = {lead_rel[6:0], 1'b0} - 8'd1;
        col      = trail - kgbp_pkg::TRAIL_LO_BIAS;
        if (trail_hi)
        begin
            row = row + 8'd1;
            col = trail - kgbp_pkg::TRAIL_HI_BIAS;
        end
        else if (col > kgbp_pkg::COL_SKIP)
        begin
            col = col - 8'd1;
        end
    end

    assign pair_ok = (lead_a || lead_b) && (trail_lo || trail_hi);
    assign set1    = pair_ok && (row >= kgbp_pkg::ROW_SET1_LO) && (row <= kgbp_pkg::ROW_SET1_HI);
    assign set2    = pair_ok && (row >= kgbp_pkg::ROW_SET2_LO) && (row <= kgbp_pkg::ROW_SET2_HI);

    // Rows are 96 cells apart: 96 = 64 + 32, done with shifts.
    assign row_rel = row - (set2 ? kgbp_pkg::ROW_SET2_LO : kgbp_pkg::ROW_BASE);
    assign row_off = {1'b0, row_rel[4:0], 6'd0} + {2'b00, row_rel[4:0], 5'd0};
    assign col_off = {5'd0, 7'(col - kgbp_pkg::COL_BASE)};

    // Final index: direct ASCII, one of the two kanji sets, or the blank glyph.
    always_comb
    begin
        if ((char_code >= kgbp_pkg::ASCII_FIRST) && (char_code <= kgbp_pkg::ASCII_LAST))
        begin
            glyph = 12'(char_code - kgbp_pkg::ASCII_FIRST);
        end
        else if (set1)
        begin
            glyph = row_off + col_off;
        end
        else if (set2)
        begin
            glyph = kgbp_pkg::SET2_GLYPH_BASE + row_off + col_off;
        end
        else
        begin
            glyph = '0;
        end
    end

endmodule

@@ design/kgbp_blit_calc.sv @@
// ----------------------------------------------------------------------------
// kgbp_blit_calc
// Clips one character cell against the window and forms its blit command.
// ----------------------------------------------------------------------------
module kgbp_blit_calc (
    input  kgbp_pkg::char_item_t                item,
    input  logic signed [kgbp_pkg::PEN_W-1:0]   pen,
    input  kgbp_pkg::cfg_t                      cfg,
    output logic                                emit,
    output kgbp_pkg::blit_item_t                blit
);

    localparam int W = kgbp_pkg::CALC_W;

    logic [11:0]         glyph;
    logic signed [W-1:0] wid;
    logic signed [W-1:0] x;
    logic signed [W-1:0] x_min;
    logic signed [W-1:0] x_max;
    logic signed [W-1:0] y;
    logic signed [W-1:0] top;
    logic signed [W-1:0] y_max;
    logic signed [W-1:0] h_cut;
    logic signed [W-1:0] y_off;
    logic signed [W-1:0] height;
    logic                above_top;
    logic                clip_l;
    logic signed [W-1:0] l_off;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] w_l;
    logic signed [W-1:0] w;
    logic                h_ok;
    logic                x_ok;

    kgbp_glyph_index u_glyph (
        .char_code (item.char_code),
        .glyph     (glyph)
    );

    // Operands at common signed width.
    assign wid   = W'(signed'({1'b0, kgbp_pkg::char_width(item.char_code)}));
    assign x     = W'(pen);
    assign x_min = W'(cfg.clip_left);
    assign x_max = x_min + W'(signed'({1'b0, cfg.clip_width}));
    assign y     = W'(cfg.line_start_y);
    assign top   = W'(cfg.clip_top);
    assign y_max = top + W'(signed'({1'b0, cfg.clip_height}));

    // Vertical clip: cut at the bottom edge, then take off the top offset.
    assign above_top = y < top;
    assign h_cut     = (y + W'(kgbp_pkg::CELL_SIZE) > y_max) ? (y_max - y)
                                                             : W'(kgbp_pkg::CELL_SIZE);
    assign y_off     = above_top ? (top - y) : '0;
    assign height    = h_cut - y_off;
    assign h_ok      = height > 0;

    // Horizontal visibility and clip.
    assign x_ok   = (x + wid > x_min) && (x < x_max);
    assign clip_l = x < x_min;
    assign l_off  = clip_l ? (x_min - x) : '0;
    assign dx     = clip_l ? x_min : x;
    assign w_l    = wid - l_off;
    assign w      = (dx + w_l > x_max) ? (x_max - dx) : w_l;

    assign emit = h_ok && x_ok;

    // Result fields; the offsets are below one cell whenever a result is emitted.
    always_comb
    begin
        blit.dest_x      = dx[15:0];
        blit.dest_y      = above_top ? cfg.clip_top : cfg.line_start_y;
        blit.blit_width  = w[4:0];
        blit.blit_height = height[4:0];
        blit.source_x    = {glyph[4:0], 4'd0} + {5'd0, l_off[3:0]};
        blit.source_y    = {1'b0, glyph[11:5], 4'd0} + {8'd0, y_off[3:0]};
        blit.raster_op   = cfg.transparent_mode;
        blit.is_last     = item.last_of_line;
    end

endmodule

@@ design/kanji_glyph_blit_planner_core.sv @@
// ----------------------------------------------------------------------------
// kanji_glyph_blit_planner_core
// Turns a stream of character codes into clipped glyph blit commands.
// ----------------------------------------------------------------------------
// The block accepts one character beat per clock while char_stall is low and
// returns at most one blit beat for it, held in the output register until taken.
// The rate is set by the pen update, a single add with saturation done in the
// accept cycle; decode and clipping run in one stage between the input
// register and the output register. Characters that are clipped away give no
// output beat but still advance the pen. Configuration writes are taken at
// any time (cfg_ready is always high) and must only be issued while the block
// is idle; writing line_start_x also reloads the pen.
module kanji_glyph_blit_planner_core (
    input  logic                  clk,
    input  logic                  rst_n,
    // Character input channel.
    input  logic                  char_valid,
    output logic                  char_stall,
    input  kgbp_pkg::char_item_t  char_data,
    // Blit command output channel.
    output logic                  blit_valid,
    input  logic                  blit_stall,
    output kgbp_pkg::blit_item_t  blit_data,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int PW = kgbp_pkg::PEN_W;

    kgbp_pkg::cfg_t        cfg;
    logic                  line_start_wr;

    logic signed [PW-1:0]  pen_reg;
    logic signed [PW-1:0]  pen_next;
    logic signed [PW:0]    pen_sum;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    kgbp_pkg::char_item_t  in_item_reg;
    logic signed [PW-1:0]  in_pen_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    kgbp_pkg::blit_item_t  out_item_reg;

    logic                  accept;
    logic                  advance;
    logic                  emit;
    kgbp_pkg::blit_item_t  blit_comb;

    assign cfg_ready = 1'b1;

    kgbp_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (cfg_valid),
        .wr_index      (cfg_index),
        .wr_data       (cfg_data),
        .cfg           (cfg),
        .line_start_wr (line_start_wr)
    );

    // Handshake: the stage moves on when the output register is free or drains.
    assign advance    = !out_valid_reg || !blit_stall;
    assign char_stall = in_valid_reg && !advance;
    assign accept     = char_valid && !char_stall;

    // Pen advance with saturation, reload at line end or line start write.
    assign pen_sum = (PW+1)'(pen_reg) +
                     (PW+1)'(signed'({1'b0, kgbp_pkg::char_width(char_data.char_code)}));
    always_comb
    begin
        pen_next = pen_reg;
        if (line_start_wr)
        begin
            pen_next = PW'($signed(cfg_data));
        end
        else if (accept)
        begin
            if (char_data.last_of_line)
            begin
                pen_next = PW'(cfg.line_start_x);
            end
            else if (pen_sum > (PW+1)'(kgbp_pkg::PEN_MAX))
            begin
                pen_next = kgbp_pkg::PEN_MAX;
            end
            else
            begin
                pen_next = pen_sum[PW-1:0];
            end
        end
    end

    // Input stage occupancy.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    kgbp_blit_calc u_calc (
        .item (in_item_reg),
        .pen  (in_pen_reg),
        .cfg  (cfg),
        .emit (emit),
        .blit (blit_comb)
    );

    // Output register occupancy; clipped-away characters leave no beat.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg && emit;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pen_reg       <= pen_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= char_data;
            in_pen_reg  <= pen_reg;
        end
        if (advance && in_valid_reg && emit)
        begin
            out_item_reg <= blit_comb;
        end
    end

    assign blit_valid = out_valid_reg;
    assign blit_data  = out_item_reg;

endmodule

@@ tb/sv/kanji_glyph_blit_planner_core_test.sv @@
// ----------------------------------------------------------------------------
// kanji_glyph_blit_planner_core_test
// Self-checking testbench for the kanji glyph blit planner. A model of the pen,
// the ASCII and Shift-JIS glyph decode and the window clip predicts each blit
// beat. Every blit beat is checked field by field against the oldest
// prediction. The run covers directed decode edges, extreme windows, a line
// that carries the pen past the 16-bit range, and random windows with random
// idling on both channels.
// ----------------------------------------------------------------------------
module kanji_glyph_blit_planner_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it; writes to it are dropped.
    localparam logic [2:0] REG_INDEX_SPARE = 3'd7;
    localparam int DIRECTED_COUNT = 26;
    localparam int PEN_LIMIT = 131071;

    // Tracks the block's configuration and pen and holds the blit beats that
    // are still owed.
    class blit_plan_checker;
        int clip_left;
        int clip_top;
        int clip_width;
        int clip_height;
        int line_start_x;
        int line_start_y;
        bit transparent;
        int pen_x;
        kgbp_pkg::blit_item_t pending[$];
        int mismatches;
        int checked;

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function void set_reg(logic [2:0] index, logic [15:0] value);
            case (index)
                kgbp_pkg::REG_CLIP_LEFT:        clip_left = $signed(value);
                kgbp_pkg::REG_CLIP_TOP:         clip_top = $signed(value);
                kgbp_pkg::REG_CLIP_WIDTH:       clip_width = value[14:0];
                kgbp_pkg::REG_CLIP_HEIGHT:      clip_height = value[14:0];
                kgbp_pkg::REG_LINE_START_X:
                begin
                    line_start_x = $signed(value);
                    pen_x = line_start_x;
                end
                kgbp_pkg::REG_LINE_START_Y:     line_start_y = $signed(value);
                kgbp_pkg::REG_TRANSPARENT_MODE: transparent = value[0];
                default: ;
            endcase
        endfunction

        // Glyph number in the font sheet: ASCII directly, Shift-JIS through its
        // JIS row and column, anything without a cell falls back to glyph 0.
        function int unsigned glyph_of(logic [15:0] code);
            int unsigned lead;
            int unsigned trail;
            int unsigned row;
            int unsigned col;
            int unsigned jis;
            lead = code[7:0];
            trail = code[15:8];
            if (code >= 16'h0020 && code <= 16'h007F)
                return code - 16'h0020;
            if ((lead >= 'h81 && lead <= 'h84) || (lead >= 'h87 && lead <= 'h9F))
                row = 2 * (lead - 'h70) - 1;
            else if (lead >= 'hE0 && lead <= 'hEF)
                row = 2 * (lead - 'hB0) - 1;
            else
                return 0;
            if (trail >= 'h40 && trail <= 'h9E && trail != 'h7F)
            begin
                col = trail - 31;
                if (col > 95)
                    col = col - 1;
            end
            else if (trail >= 'h9F && trail <= 'hFC)
            begin
                col = trail - 126;
                row = row + 1;
            end
            else
                return 0;
            jis = (row << 8) | col;
            if (jis >= 'h2120 && jis < 'h2820)
                return (row - 'h20) * 96 + (col - 'h20);
            if (jis >= 'h3020 && jis < 'h5020)
                return 1024 + (row - 'h30) * 96 + (col - 'h20);
            return 0;
        endfunction

        // Works out the blit for an accepted character, if any, and moves the pen.
        function void note_char(kgbp_pkg::char_item_t beat);
            int wid;
            int x_max;
            int y;
            int y_max;
            int height;
            int y_off;
            int dx;
            int w;
            int sx;
            int sy;
            int next_pen;
            int unsigned glyph;
            kgbp_pkg::blit_item_t blit;
            wid = (beat.char_code <= 16'h007F) ? kgbp_pkg::CELL_SIZE / 2
                                               : kgbp_pkg::CELL_SIZE;
            x_max = clip_left + clip_width;
            y = line_start_y;
            y_max = clip_top + clip_height;
            height = kgbp_pkg::CELL_SIZE;
            y_off = 0;
            if (y + height > y_max)
                height = y_max - y;
            if (y < clip_top)
            begin
                y_off = clip_top - y;
                height = height - y_off;
                y = clip_top;
            end
            if (height > 0 && pen_x + wid > clip_left && pen_x < x_max)
            begin
                glyph = glyph_of(beat.char_code);
                sx = (glyph % kgbp_pkg::SHEET_COLUMNS) * kgbp_pkg::CELL_SIZE;
                sy = (glyph / kgbp_pkg::SHEET_COLUMNS) * kgbp_pkg::CELL_SIZE;
                dx = pen_x;
                w = wid;
                if (dx < clip_left)
                begin
                    sx = sx + clip_left - dx;
                    w = w - (clip_left - dx);
                    dx = clip_left;
                end
                if (dx + w > x_max)
                    w = x_max - dx;
                blit.dest_x = 16'(dx);
                blit.dest_y = 16'(y);
                blit.blit_width = 5'(w);
                blit.blit_height = 5'(height);
                blit.source_x = 9'(sx);
                blit.source_y = 12'(sy + y_off);
                blit.raster_op = transparent;
                blit.is_last = beat.last_of_line;
                pending.push_back(blit);
            end
            next_pen = pen_x + wid;
            if (next_pen > PEN_LIMIT)
                next_pen = PEN_LIMIT;
            pen_x = beat.last_of_line ? line_start_x : next_pen;
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, %0h predicted", name, got, want));
        endtask

        task check_blit(kgbp_pkg::blit_item_t got);
            kgbp_pkg::blit_item_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("blit beat at x %0h y %0h with nothing owed",
                                 got.dest_x, got.dest_y));
                return;
            end
            want = pending.pop_front();
            checked++;
            check_field("dest_x", got.dest_x, want.dest_x);
            check_field("dest_y", got.dest_y, want.dest_y);
            check_field("blit_width", got.blit_width, want.blit_width);
            check_field("blit_height", got.blit_height, want.blit_height);
            check_field("source_x", got.source_x, want.source_x);
            check_field("source_y", got.source_y, want.source_y);
            check_field("raster_op", got.raster_op, want.raster_op);
            check_field("is_last", got.is_last, want.is_last);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  char_valid = 1'b0;
    logic                  char_stall;
    kgbp_pkg::char_item_t  char_data = '0;
    logic                  blit_valid;
    logic                  blit_stall = 1'b0;
    kgbp_pkg::blit_item_t  blit_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [15:0]           cfg_data = '0;

    blit_plan_checker book = new;
    int idle_pct = 36;
    int chars_sent = 0;
    int window_count = 0;
    logic [15:0] directed_codes [0:DIRECTED_COUNT-1];

    kanji_glyph_blit_planner_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .blit_valid (blit_valid),
        .blit_stall (blit_stall),
        .blit_data  (blit_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    // Random back-pressure on the blit channel.
    always @(posedge clk)
        blit_stall <= ($urandom_range(99) < idle_pct);

    // Watch both channels; a blit beat always belongs to an earlier character.
    always @(posedge clk)
    begin
        if (rst_n && blit_valid && !blit_stall)
            book.check_blit(blit_data);
        if (rst_n && char_valid && !char_stall)
            book.note_char(char_data);
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // One character beat, with random idle cycles ahead of it.
    task automatic send_char(input kgbp_pkg::char_item_t beat);
        while ($urandom_range(99) < idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data <= beat;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    // One register write; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.set_reg(index, value);
    endtask

    task automatic program_window(input logic [15:0] left, input logic [15:0] top,
                                  input logic [14:0] width, input logic [14:0] height,
                                  input logic [15:0] start_x, input logic [15:0] start_y,
                                  input logic mode);
        write_reg(kgbp_pkg::REG_CLIP_LEFT, left);
        write_reg(kgbp_pkg::REG_CLIP_TOP, top);
        write_reg(kgbp_pkg::REG_CLIP_WIDTH, {1'b0, width});
        write_reg(kgbp_pkg::REG_CLIP_HEIGHT, {1'b0, height});
        write_reg(kgbp_pkg::REG_LINE_START_X, start_x);
        write_reg(kgbp_pkg::REG_LINE_START_Y, start_y);
        write_reg(kgbp_pkg::REG_TRANSPARENT_MODE, {15'($urandom()), mode});
        write_reg(REG_INDEX_SPARE, 16'($urandom()));
        cfg_valid <= 1'b0;
        window_count++;
    endtask

    // A window placed around the line start so that most lines land in or
    // across it; now and then the window is huge.
    task automatic program_random_window();
        logic [15:0] home_x;
        logic [15:0] home_y;
        logic [14:0] span_x;
        logic [14:0] span_y;
        home_x = 16'($urandom());
        home_y = 16'($urandom());
        span_x = ($urandom_range(9) == 0) ? 15'($urandom()) : 15'($urandom_range(320));
        span_y = ($urandom_range(9) == 0) ? 15'($urandom()) : 15'($urandom_range(40));
        program_window(home_x + 16'($urandom_range(128)) - 16'd64,
                       home_y + 16'($urandom_range(40)) - 16'd20,
                       span_x, span_y, home_x, home_y, 1'($urandom_range(1)));
    endtask

    // Mostly printable ASCII and well-formed Shift-JIS pairs, some control
    // codes and some arbitrary words.
    function automatic logic [15:0] pick_char_code();
        logic [7:0] lead;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return 16'($urandom_range(16'h0020, 16'h007F));
        if (sel < 32)
            return 16'($urandom_range(16'h001F));
        if (sel < 80)
        begin
            case ($urandom_range(2))
                0:       lead = 8'($urandom_range(8'h81, 8'h84));
                1:       lead = 8'($urandom_range(8'h87, 8'h9F));
                default: lead = 8'($urandom_range(8'hE0, 8'hEF));
            endcase
            return {8'($urandom_range(8'h40, 8'hFC)), lead};
        end
        return 16'($urandom());
    endfunction

    task automatic run_chars(input int count, input int last_pct);
        kgbp_pkg::char_item_t beat;
        for (int i = 0; i < count; i++)
        begin
            beat.char_code = pick_char_code();
            beat.last_of_line = ($urandom_range(99) < last_pct);
            send_char(beat);
        end
    endtask

    // Let every owed blit drain, then allow for the pipeline depth.
    task automatic finish_phase();
        char_valid <= 1'b0;
        @(posedge clk);
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    initial
    begin
        kgbp_pkg::char_item_t beat;
        directed_codes = '{16'h0041, 16'h0020, 16'h007F, 16'h0000, 16'h001F, 16'h0080,
                           16'h00FF, 16'h4081, 16'hFC84, 16'h9E84, 16'h4085, 16'h4086,
                           16'h4087, 16'h9F88, 16'hFC9F, 16'h4098, 16'h7F89, 16'h3F89,
                           16'hFD89, 16'h80E0, 16'h40EF, 16'h40A0, 16'h40DF, 16'h40F0,
                           16'hFFFF, 16'h0041};

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decode edges in a 200 pixel window; the line starts 4 pixels left of
        // it and runs past its right edge before the closing line breaks.
        program_window(16'h0000, 16'h0000, 15'd200, 15'd16, 16'hFFFC, 16'h0000, 1'b0);
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            beat.char_code = directed_codes[i];
            beat.last_of_line = (i >= DIRECTED_COUNT - 3);
            send_char(beat);
        end
        finish_phase();

        // Empty window: nothing may come out.
        program_window(16'h0000, 16'h0000, 15'd0, 15'd0, 16'h0000, 16'h0000, 1'b0);
        run_chars(12, 10);
        finish_phase();

        // Most negative corner with the widest window.
        program_window(16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 16'h8000, 16'h8000, 1'b1);
        run_chars(30, 4);
        finish_phase();

        // Most positive corner; dest_x runs past the 16-bit range.
        program_window(16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 16'h7FEC, 16'h7FFF, 1'b0);
        run_chars(30, 4);
        finish_phase();

        // Line starts above the window top and its cell passes the bottom.
        program_window(16'h0000, 16'd100, 15'd300, 15'd10, 16'h0000, 16'd95, 1'b1);
        run_chars(30, 8);
        finish_phase();

        // Cell cut at the bottom edge only.
        program_window(16'h0000, 16'h0000, 15'd300, 15'd20, 16'h0000, 16'd10, 1'b0);
        run_chars(30, 8);
        finish_phase();

        // Height of zero and below zero: no blits, pen keeps moving.
        program_window(16'h0000, 16'h0000, 15'd300, 15'd5, 16'h0000, 16'd5, 1'b1);
        run_chars(15, 8);
        finish_phase();
        program_window(16'h0000, 16'h0000, 15'd300, 15'd5, 16'h0000, 16'd30, 1'b0);
        run_chars(15, 8);
        finish_phase();

        // A line of full-width characters that carries the pen well past the
        // 16-bit range while it stays inside a wide window.
        program_window(16'h7F00, 16'h0000, 15'h7FFF, 15'd16, 16'h7FF0, 16'h0000, 1'b0);
        for (int i = 0; i < 60; i++)
        begin
            beat.char_code = 16'($urandom_range(16'h0080, 16'hFFFF));
            beat.last_of_line = (i == 59);
            send_char(beat);
        end
        run_chars(10, 0);
        finish_phase();

        // Random windows; one stretch runs with no idling on either side.
        for (int phase = 0; phase < 8; phase++)
        begin
            idle_pct = (phase == 4) ? 0 : 36;
            program_random_window();
            run_chars((phase == 4) ? 100 : 25, 7);
            finish_phase();
        end

        $display("Ran %0d character beats through %0d window settings.",
                 chars_sent, window_count);
        $display("Compared %0d blit beats over ASCII and Shift-JIS decode and clipping.",
                 book.checked);
        if (book.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
